@@ rtl/cba_pkg.sv @@
// shared constants and codes of the contiguous block allocator
`default_nettype none

package cba_pkg;

   localparam int MAP_BLOCKS  = 256;
   localparam int BLOCK_BYTES = 1024;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int IDX_W       = $clog2(MAP_BLOCKS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int ADDR_W      = 32;
   localparam int BYTES_W     = 24;
   localparam int STATUS_W    = 3;
   localparam int BLOCKS_W    = 9;
   localparam int NEED_W      = BYTES_W - BLOCK_SHIFT + 1;

   // map entry codes
   localparam logic [1:0] ENTRY_EMPTY = 2'd0;
   localparam logic [1:0] ENTRY_HEAD  = 2'd1;
   localparam logic [1:0] ENTRY_TAIL  = 2'd2;

   // commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_SET_UP    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_BOUNDS = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_HEAD      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE      = 3'd6;

   // register indexes
   localparam logic CSR_BASE_ADDRESS   = 1'b0;
   localparam logic CSR_MANAGED_BLOCKS = 1'b1;

endpackage

`default_nettype wire

@@ rtl/cba_req_if.sv @@
// request channel: command, byte count and address to free
`default_nettype none

interface cba_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [cba_pkg::BYTES_W-1:0] request_bytes;
   logic [cba_pkg::ADDR_W-1:0]  address;

   modport source (output valid, output cmd, output request_bytes, output address,
                   input ready);
   modport sink   (input valid, input cmd, input request_bytes, input address,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/cba_rsp_if.sv @@
// response channel: status and allocated block address
`default_nettype none

interface cba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cba_pkg::STATUS_W-1:0] status;
   logic [cba_pkg::ADDR_W-1:0]   block_address;

   modport source (output valid, output status, output block_address, input ready);
   modport sink   (input valid, input status, input block_address, output ready);
endinterface

`default_nettype wire

@@ rtl/contiguous_block_allocator.sv @@
// first-fit allocator over a block map held in one synchronous memory
//
// req_bus carries an allocate (byte count) or free (address) item; rsp_bus
// returns one status and block address for each item, in order. registers
// base_address (index 0) and managed_blocks (index 1) are written through
// csr_wr_en / csr_index / csr_wdata; the user must write them only while
// no item is in flight, and the block itself does not enforce it.
// the work is paced by the single map memory, one entry read or written a cycle:
//   an allocate scans up to n entries, for n managed blocks, and then marks
//   the run it found; a free reads the head and clears the following tails;
//   requests that fail their checks go straight to the result.
// one item is worked on at a time; req ready is high whenever no item is
// in work and the clear pass is over. the result sits in an output register,
// so the next item is taken while a result still waits; if the receiver
// stalls, a finished item waits until that register is free.
// after reset the map is cleared by a pass over all 256 entries (one entry
// a cycle) with req ready low; register writes are taken during that pass.
`default_nettype none

module contiguous_block_allocator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cba_req_if.sink                            req_bus,
   cba_rsp_if.source                          rsp_bus,
   input  wire logic                          csr_wr_en,
   input  wire logic                          csr_index,
   input  wire logic [cba_pkg::ADDR_W-1:0]    csr_wdata
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_MARK  = 3'd3;
   localparam logic [2:0] S_FHEAD = 3'd4;
   localparam logic [2:0] S_FTAIL = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam int IW = cba_pkg::IDX_W;
   localparam int CW = cba_pkg::CNT_W;
   localparam int AW = cba_pkg::ADDR_W;
   localparam int BS = cba_pkg::BLOCK_SHIFT;
   localparam int NW = cba_pkg::NEED_W;
   localparam int OW = AW - BS;

   logic [1:0] map_mem [cba_pkg::MAP_BLOCKS];
   logic [1:0] mem_rdata_ff;
   logic       mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [1:0] mem_wdata;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] chk_ff, chk_in;
   logic [CW-1:0] run_ff, run_in;
   logic [CW-1:0] need_ff, need_in;
   logic [IW-1:0] start_ff, start_in;
   logic [IW-1:0] end_ff, end_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [cba_pkg::STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [cba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;
   logic [AW-1:0] base_ff, base_in;
   logic [cba_pkg::BLOCKS_W-1:0] blocks_ff, blocks_in;

   logic [CW-1:0] act_blocks;
   logic          accept;
   logic [cba_pkg::BYTES_W-1:0] bytes_dec;
   logic [NW-1:0] need_full;
   logic [AW-1:0] offset;
   logic [CW-1:0] chk_p1;
   logic [CW-1:0] run_p1;
   logic          out_free;

   // blocks beyond the map size are treated as the map size
   assign act_blocks = (blocks_ff > cba_pkg::BLOCKS_W'(cba_pkg::MAP_BLOCKS))
                       ? CW'(cba_pkg::MAP_BLOCKS) : CW'(blocks_ff);

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign bytes_dec     = req_bus.request_bytes - cba_pkg::BYTES_W'(1);
   assign need_full     = NW'(bytes_dec[cba_pkg::BYTES_W-1:BS]) + NW'(1);
   assign offset        = req_bus.address - base_ff;
   assign chk_p1        = chk_ff + CW'(1);
   assign run_p1        = run_ff + CW'(1);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.block_address = rsp_addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= map_mem[mem_raddr];
   end

   always_comb begin
      base_in   = base_ff;
      blocks_in = blocks_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            cba_pkg::CSR_BASE_ADDRESS:   base_in = csr_wdata;
            cba_pkg::CSR_MANAGED_BLOCKS: blocks_in = csr_wdata[cba_pkg::BLOCKS_W-1:0];
            default:                     base_in = base_ff;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      chk_in         = chk_ff;
      run_in         = run_ff;
      need_in        = need_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      clr_in         = clr_ff;
      pend_status_in = pend_status_ff;
      pend_addr_in   = pend_addr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      mem_we         = 1'b0;
      mem_waddr      = chk_ff[IW-1:0];
      mem_wdata      = cba_pkg::ENTRY_EMPTY;
      mem_raddr      = chk_p1[IW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + IW'(1);
            if (clr_ff == IW'(cba_pkg::MAP_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               pend_addr_in = '0;
               state_in     = S_DONE;
               if (act_blocks == '0) begin
                  pend_status_in = cba_pkg::ST_NOT_SET_UP;
               end else if (req_bus.cmd == cba_pkg::CMD_ALLOC) begin
                  if (req_bus.request_bytes == '0 || need_full > NW'(act_blocks)) begin
                     pend_status_in = cba_pkg::ST_NO_SPACE;
                  end else begin
                     mem_raddr = '0;
                     chk_in    = '0;
                     run_in    = '0;
                     need_in   = need_full[CW-1:0];
                     state_in  = S_SCAN;
                  end
               end else if (req_bus.address < base_ff ||
                            offset[AW-1:BS] >= OW'(act_blocks)) begin
                  pend_status_in = cba_pkg::ST_OUT_OF_BOUNDS;
               end else if (offset[BS-1:0] != '0) begin
                  pend_status_in = cba_pkg::ST_MISALIGNED;
               end else begin
                  mem_raddr = offset[BS+IW-1:BS];
                  chk_in    = CW'(offset[BS+IW-1:BS]);
                  state_in  = S_FHEAD;
               end
            end
         end
         S_SCAN: begin
            if (mem_rdata_ff == cba_pkg::ENTRY_EMPTY && run_p1 == need_ff) begin
               // run found: mark it from its first block on
               start_in = IW'(chk_p1 - need_ff);
               end_in   = chk_ff[IW-1:0];
               chk_in   = chk_p1 - need_ff;
               state_in = S_MARK;
            end else begin
               run_in = (mem_rdata_ff == cba_pkg::ENTRY_EMPTY) ? run_p1 : '0;
               if (chk_p1 < act_blocks) begin
                  chk_in = chk_p1;
               end else begin
                  pend_status_in = cba_pkg::ST_NO_SPACE;
                  pend_addr_in   = '0;
                  state_in       = S_DONE;
               end
            end
         end
         S_MARK: begin
            mem_we    = 1'b1;
            mem_wdata = (chk_ff[IW-1:0] == start_ff) ? cba_pkg::ENTRY_HEAD
                                                     : cba_pkg::ENTRY_TAIL;
            chk_in    = chk_p1;
            if (chk_ff[IW-1:0] == end_ff) begin
               pend_status_in = cba_pkg::ST_OK;
               pend_addr_in   = base_ff + (AW'(start_ff) << BS);
               state_in       = S_DONE;
            end
         end
         S_FHEAD: begin
            pend_addr_in = '0;
            if (mem_rdata_ff == cba_pkg::ENTRY_HEAD) begin
               mem_we = 1'b1;
               if (chk_p1 < act_blocks) begin
                  chk_in   = chk_p1;
                  state_in = S_FTAIL;
               end else begin
                  pend_status_in = cba_pkg::ST_OK;
                  state_in       = S_DONE;
               end
            end else if (mem_rdata_ff == cba_pkg::ENTRY_EMPTY) begin
               pend_status_in = cba_pkg::ST_ALREADY_FREE;
               state_in       = S_DONE;
            end else begin
               pend_status_in = cba_pkg::ST_NOT_HEAD;
               state_in       = S_DONE;
            end
         end
         S_FTAIL: begin
            // clear tails until a non-tail entry or the managed end
            if (mem_rdata_ff == cba_pkg::ENTRY_TAIL) begin
               mem_we = 1'b1;
               if (chk_p1 < act_blocks) begin
                  chk_in = chk_p1;
               end else begin
                  pend_status_in = cba_pkg::ST_OK;
                  state_in       = S_DONE;
               end
            end else begin
               pend_status_in = cba_pkg::ST_OK;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_addr_in   = pend_addr_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         blocks_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         blocks_ff    <= blocks_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff         <= chk_in;
      run_ff         <= run_in;
      need_ff        <= need_in;
      start_ff       <= start_in;
      end_ff         <= end_in;
      pend_status_ff <= pend_status_in;
      pend_addr_ff   <= pend_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_addr_ff    <= rsp_addr_in;
   end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking bench for the contiguous block allocator: first-fit map predictor, in-order check
import cba_pkg::*;

typedef struct packed {
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   block_address;
} alloc_result_type;

class alloc_scoreboard;
   logic [ADDR_W-1:0]   base_address;
   logic [BLOCKS_W-1:0] managed_blocks;
   logic [1:0]          block_map [MAP_BLOCKS];
   alloc_result_type    expected_q [$];
   int                  errors;

   function new();
      base_address   = '0;
      managed_blocks = '0;
      foreach (block_map[i]) block_map[i] = ENTRY_EMPTY;
      errors = 0;
   endfunction

   function void write_reg(logic index, logic [ADDR_W-1:0] value);
      if (index == CSR_BASE_ADDRESS) begin
         base_address = value;
      end else begin
         managed_blocks = value[BLOCKS_W-1:0];
      end
   endfunction

   // counts above the map size are clamped
   function int active_blocks();
      return (managed_blocks > MAP_BLOCKS) ? MAP_BLOCKS : int'(managed_blocks);
   endfunction

   function alloc_result_type first_fit(logic [BYTES_W-1:0] bytes);
      alloc_result_type r;
      int n, need, run, start, j, k;
      n = active_blocks();
      r.status        = ST_NO_SPACE;
      r.block_address = '0;
      if (n == 0) begin
         r.status = ST_NOT_SET_UP;
         return r;
      end
      if (bytes == 0) return r;
      need = (int'(bytes) - 1) / BLOCK_BYTES + 1;
      if (need > n) return r;
      run = 0;
      for (j = 0; j < n; j++) begin
         if (block_map[j] == ENTRY_EMPTY) begin
            run++;
            if (run >= need) begin
               start = j + 1 - need;
               block_map[start] = ENTRY_HEAD;
               for (k = start + 1; k <= j; k++) block_map[k] = ENTRY_TAIL;
               r.status        = ST_OK;
               r.block_address = base_address + ADDR_W'(start * BLOCK_BYTES);
               return r;
            end
         end else begin
            run = 0;
         end
      end
      return r;
   endfunction

   function alloc_result_type free_run(logic [ADDR_W-1:0] addr);
      alloc_result_type r;
      int n, idx, i;
      logic [ADDR_W-1:0] offset;
      n = active_blocks();
      r.status        = ST_OK;
      r.block_address = '0;
      if (n == 0) begin
         r.status = ST_NOT_SET_UP;
      end else if (addr < base_address) begin
         r.status = ST_OUT_OF_BOUNDS;
      end else begin
         offset = addr - base_address;
         // end of the region is computed without wrap
         if (64'(offset) >= 64'(n) * BLOCK_BYTES) begin
            r.status = ST_OUT_OF_BOUNDS;
         end else if (offset % BLOCK_BYTES != 0) begin
            r.status = ST_MISALIGNED;
         end else begin
            idx = int'(offset / BLOCK_BYTES);
            if (block_map[idx] == ENTRY_HEAD) begin
               block_map[idx] = ENTRY_EMPTY;
               i = idx + 1;
               while (i < n && block_map[i] == ENTRY_TAIL) begin
                  block_map[i] = ENTRY_EMPTY;
                  i++;
               end
            end else if (block_map[idx] == ENTRY_EMPTY) begin
               r.status = ST_ALREADY_FREE;
            end else begin
               r.status = ST_NOT_HEAD;
            end
         end
      end
      return r;
   endfunction

   function void note_request(logic cmd, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] addr);
      if (cmd == CMD_ALLOC) begin
         expected_q.push_back(first_fit(bytes));
      end else begin
         expected_q.push_back(free_run(addr));
      end
   endfunction

   function void check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] addr);
      alloc_result_type want;
      if (expected_q.size() == 0) begin
         $error("unexpected result: status %0d block_address %h", status, addr);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      if (status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, status);
         errors++;
      end
      if (addr !== want.block_address) begin
         $error("block_address: expected %h, got %h", want.block_address, addr);
         errors++;
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void check_drained();
      if (expected_q.size() != 0) begin
         $error("%0d results never arrived", expected_q.size());
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int IDLE_LIMIT       = 4000;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_EVERY      = 150;
   localparam int SETTLE_CYCLES    = 2 * MAP_BLOCKS + 16;
   localparam int PHASES           = 8;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic              csr_index;
   logic [ADDR_W-1:0] csr_wdata;

   cba_req_if req_bus();
   cba_rsp_if rsp_bus();

   contiguous_block_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   alloc_scoreboard allocs = new();

   int results_seen = 0;
   int idle_cycles  = 0;
   int stall_left   = 0;
   int send_burst   = 0;
   int recv_burst   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int idle_len(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst = $urandom_range(10, 40);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side: check each item, then pick the next stall
   always @(posedge clock) begin : rsp_side
      int gap;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         allocs.check_result(rsp_bus.status, rsp_bus.block_address);
         results_seen++;
         gap = (results_seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : idle_len(recv_burst);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = gap - 1;
         end
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(logic cmd, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] addr);
      int gap;
      gap = idle_len(send_burst);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= cmd;
      req_bus.request_bytes <= bytes;
      req_bus.address       <= addr;
      do @(posedge clock); while (!req_bus.ready);
      allocs.note_request(cmd, bytes, addr);
   endtask

   task automatic wait_drained(int settle);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (allocs.pending() > 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic configure(logic [ADDR_W-1:0] base, logic [BLOCKS_W-1:0] blocks);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BASE_ADDRESS;
      csr_wdata <= base;
      @(posedge clock);
      allocs.write_reg(CSR_BASE_ADDRESS, base);
      csr_index <= CSR_MANAGED_BLOCKS;
      csr_wdata <= ADDR_W'(blocks);
      @(posedge clock);
      allocs.write_reg(CSR_MANAGED_BLOCKS, ADDR_W'(blocks));
      csr_wr_en <= 1'b0;
   endtask

   // mostly allocations and frees of live runs, some broken addresses
   task automatic send_random_item();
      int n, pick, idx, i;
      int heads [$];
      logic              cmd;
      logic [BYTES_W-1:0] bytes;
      logic [ADDR_W-1:0]  addr;
      n     = allocs.active_blocks();
      cmd   = CMD_FREE;
      bytes = BYTES_W'($urandom);
      addr  = $urandom;
      pick  = $urandom_range(0, 99);
      if (pick < 45) begin
         cmd  = CMD_ALLOC;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            bytes = BYTES_W'($urandom_range(1, 4 * BLOCK_BYTES));
         end else if (pick < 88) begin
            bytes = BYTES_W'($urandom_range(1, (n > 0 ? n : 1) * BLOCK_BYTES));
         end else if (pick < 97 && pick >= 94) begin
            bytes = '0;
         end else if (pick >= 97) begin
            bytes = '1;
         end
      end else if (pick < 85) begin
         for (i = 0; i < n; i++) begin
            if (allocs.block_map[i] == ENTRY_HEAD) heads.push_back(i);
         end
         if (heads.size() > 0 && $urandom_range(0, 99) < 70) begin
            idx = heads[$urandom_range(0, heads.size() - 1)];
         end else begin
            idx = $urandom_range(0, n > 0 ? n - 1 : 3);
         end
         addr = allocs.base_address + ADDR_W'(idx * BLOCK_BYTES);
      end else begin
         pick = $urandom_range(0, 3);
         case (pick)
            0: ;
            1: addr = allocs.base_address - ADDR_W'($urandom_range(1, BLOCK_BYTES));
            2: addr = allocs.base_address + ADDR_W'(n * BLOCK_BYTES)
                      + ADDR_W'($urandom_range(0, 3) * BLOCK_BYTES);
            default: addr = allocs.base_address
                            + ADDR_W'($urandom_range(0, n > 0 ? n - 1 : 0) * BLOCK_BYTES)
                            + ADDR_W'($urandom_range(1, BLOCK_BYTES - 1));
         endcase
      end
      send_item(cmd, bytes, addr);
   endtask

   initial begin
      logic [ADDR_W-1:0]   phase_base   [PHASES];
      logic [BLOCKS_W-1:0] phase_blocks [PHASES];
      int                  phase_items  [PHASES];
      logic [ADDR_W-1:0]   b;
      int                  p, k;

      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.cmd           <= CMD_ALLOC;
      req_bus.request_bytes <= '0;
      req_bus.address       <= '0;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_BASE_ADDRESS;
      csr_wdata             <= '0;

      phase_base[0] = $urandom & ~32'h3FF; phase_blocks[0] = 9'd32;  phase_items[0] = 300;
      phase_base[1] = $urandom;            phase_blocks[1] = 9'd1;   phase_items[1] = 150;
      phase_base[2] = '0;                  phase_blocks[2] = 9'd16;  phase_items[2] = 300;
      phase_base[3] = $urandom;            phase_blocks[3] = 9'd0;   phase_items[3] = 60;
      phase_base[4] = '1;                  phase_blocks[4] = 9'd8;   phase_items[4] = 150;
      phase_base[5] = $urandom;            phase_blocks[5] = 9'd256; phase_items[5] = 250;
      phase_base[6] = $urandom & ~32'h3FF; phase_blocks[6] = 9'd64;  phase_items[6] = 300;
      phase_base[7] = $urandom;            phase_blocks[7] = '1;     phase_items[7] = 200;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // registers still at reset: nothing is set up
      send_item(CMD_ALLOC, 24'd1024, '0);
      send_item(CMD_FREE, '0, '0);
      wait_drained(8);

      b = 32'h0001_0000;
      configure(b, 9'd256);
      send_item(CMD_ALLOC, '0, '0);
      send_item(CMD_ALLOC, '1, '0);
      send_item(CMD_ALLOC, 24'd262144, '0);   // the whole map in one run
      send_item(CMD_ALLOC, 24'd1, '0);        // map full
      send_item(CMD_FREE, '0, b);
      send_item(CMD_ALLOC, 24'd262145, '0);
      send_item(CMD_ALLOC, 24'd1, '0);
      send_item(CMD_ALLOC, 24'd1024, '0);
      send_item(CMD_ALLOC, 24'd1025, '0);
      send_item(CMD_ALLOC, 24'd3000, '0);
      send_item(CMD_FREE, '0, b + 32'd3072);  // tail
      send_item(CMD_FREE, '0, b + 32'd2560);
      send_item(CMD_FREE, '0, b - 32'd1);
      send_item(CMD_FREE, '0, b + 32'd262144); // end address is outside
      send_item(CMD_FREE, '0, b + 32'd261120);
      send_item(CMD_FREE, '0, b + 32'd2048);
      send_item(CMD_FREE, '0, b + 32'd2048);
      send_item(CMD_ALLOC, 24'd2048, '0);     // refills the hole
      send_item(CMD_FREE, '1, '1);
      wait_drained(SETTLE_CYCLES);

      // oversized count and a base that wraps past the top of the address space
      b = 32'hFFFF_FC00;
      configure(b, '1);
      send_item(CMD_ALLOC, 24'd5000, '0);
      send_item(CMD_FREE, '0, '0);
      send_item(CMD_FREE, '0, b);
      send_item(CMD_FREE, '0, '1);
      wait_drained(SETTLE_CYCLES);

      for (p = 0; p < PHASES; p++) begin
         configure(phase_base[p], phase_blocks[p]);
         for (k = 0; k < phase_items[p]; k++) begin
            if (k > 0 && k % DRAIN_EVERY == 0) wait_drained(0);
            send_random_item();
         end
         wait_drained(SETTLE_CYCLES);
      end

      allocs.check_drained();
      if (allocs.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
